FILE: design/dsmpwm_pkg.sv
// Package for the two-channel sign-magnitude motor PWM.
// Holds the request codes and the result record shared by the core and the top level.
package dsmpwm_pkg;

    localparam int unsigned DATA_W = 16;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_LEFT    = 2'd1,
        REQ_RIGHT   = 2'd2,
        REQ_DISABLE = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic                     left_pin;
        logic                     right_pin;
        logic                     left_reverse;
        logic                     right_reverse;
        logic                     outputs_enabled;
        logic signed [DATA_W-1:0] left_readback;
        logic signed [DATA_W-1:0] right_readback;
        logic        [DATA_W-1:0] count_now;
    } result_t;

endpackage

FILE: design/dsmpwm_if.sv
// Valid/ready channel interfaces for the motor PWM requests and results.
// Depends on dsmpwm_pkg for the field widths.
interface dsmpwm_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            req_type;
    logic signed [dsmpwm_pkg::DATA_W-1:0]  duty;

    modport source (output valid, output req_type, output duty, input ready);
    modport sink (input valid, input req_type, input duty, output ready);
endinterface

interface dsmpwm_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  left_pin;
    logic                                  right_pin;
    logic                                  left_reverse;
    logic                                  right_reverse;
    logic                                  outputs_enabled;
    logic signed [dsmpwm_pkg::DATA_W-1:0]  left_readback;
    logic signed [dsmpwm_pkg::DATA_W-1:0]  right_readback;
    logic        [dsmpwm_pkg::DATA_W-1:0]  count_now;

    modport source (
        output valid, output left_pin, output right_pin, output left_reverse,
        output right_reverse, output outputs_enabled, output left_readback,
        output right_readback, output count_now, input ready
    );
    modport sink (
        input valid, input left_pin, input right_pin, input left_reverse,
        input right_reverse, input outputs_enabled, input left_readback,
        input right_readback, input count_now, output ready
    );
endinterface

FILE: design/dsmpwm_core.sv
// PWM state: shared up/down counter, buffered and active compares, directions, enable.
// Updates on each accepted transaction or config write (the write wins and drops the
// transaction); presents the post-update result. Depends on dsmpwm_pkg.
module dsmpwm_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  dsmpwm_pkg::req_kind_t                req_kind,
    input  logic signed [dsmpwm_pkg::DATA_W-1:0] duty,
    input  logic                                 cfg_we,
    input  logic [dsmpwm_pkg::DATA_W-1:0]        cfg_wdata,
    output dsmpwm_pkg::result_t                  result
);
    localparam int unsigned W = dsmpwm_pkg::DATA_W;

    logic [W-1:0] max_count_reg, max_count_next;
    logic [W-1:0] counter_reg, counter_next;
    logic         down_reg, down_next;
    logic [W-1:0] lbuf_reg, lbuf_next;
    logic [W-1:0] rbuf_reg, rbuf_next;
    logic [W-1:0] lact_reg, lact_next;
    logic [W-1:0] ract_reg, ract_next;
    logic         lrev_reg, lrev_next;
    logic         rrev_reg, rrev_next;
    logic         enable_reg, enable_next;

    logic [W-1:0] duty_mag;
    logic         duty_neg;
    logic [W-1:0] cnt_up;
    logic [W-1:0] cnt_dn;

    always_comb
    begin
        duty_neg = duty[W-1];
        duty_mag = duty_neg ? (W'(0) - W'(duty)) : W'(duty);
        cnt_up   = (counter_reg < max_count_reg) ? (counter_reg + W'(1)) : counter_reg;
        cnt_dn   = (counter_reg != W'(0)) ? (counter_reg - W'(1)) : counter_reg;

        max_count_next = max_count_reg;
        counter_next   = counter_reg;
        down_next      = down_reg;
        lbuf_next      = lbuf_reg;
        rbuf_next      = rbuf_reg;
        lact_next      = lact_reg;
        ract_next      = ract_reg;
        lrev_next      = lrev_reg;
        rrev_next      = rrev_reg;
        enable_next    = enable_reg;

        if (cfg_we)
        begin
            max_count_next = cfg_wdata;
            counter_next   = '0;
            down_next      = 1'b0;
        end
        else if (accept)
        begin
            case (req_kind)
                dsmpwm_pkg::REQ_TICK:
                begin
                    if (!down_reg)
                    begin
                        counter_next = cnt_up;
                        if (cnt_up >= max_count_reg)
                        begin
                            down_next = 1'b1;
                        end
                    end
                    else
                    begin
                        counter_next = cnt_dn;
                        if (cnt_dn == W'(0))
                        begin
                            down_next = 1'b0;
                            lact_next = lbuf_reg;
                            ract_next = rbuf_reg;
                        end
                    end
                end
                dsmpwm_pkg::REQ_LEFT:
                begin
                    lbuf_next   = duty_mag;
                    lrev_next   = duty_neg;
                    enable_next = 1'b1;
                end
                dsmpwm_pkg::REQ_RIGHT:
                begin
                    rbuf_next   = duty_mag;
                    rrev_next   = duty_neg;
                    enable_next = 1'b1;
                end
                dsmpwm_pkg::REQ_DISABLE:
                begin
                    enable_next = 1'b0;
                    lbuf_next   = '0;
                    rbuf_next   = '0;
                end
                default:
                begin
                    enable_next = enable_reg;
                end
            endcase
        end

        result.left_pin        = enable_next && (counter_next < lact_next);
        result.right_pin       = enable_next && (counter_next < ract_next);
        result.left_reverse    = lrev_next;
        result.right_reverse   = rrev_next;
        result.outputs_enabled = enable_next;
        result.left_readback   = lrev_next ? signed'(W'(0) - lbuf_next) : signed'(lbuf_next);
        result.right_readback  = rrev_next ? signed'(W'(0) - rbuf_next) : signed'(rbuf_next);
        result.count_now       = counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= '1;
            counter_reg   <= '0;
            down_reg      <= 1'b0;
            lbuf_reg      <= '0;
            rbuf_reg      <= '0;
            lact_reg      <= '0;
            ract_reg      <= '0;
            lrev_reg      <= 1'b0;
            rrev_reg      <= 1'b0;
            enable_reg    <= 1'b0;
        end
        else
        begin
            max_count_reg <= max_count_next;
            counter_reg   <= counter_next;
            down_reg      <= down_next;
            lbuf_reg      <= lbuf_next;
            rbuf_reg      <= rbuf_next;
            lact_reg      <= lact_next;
            ract_reg      <= ract_next;
            lrev_reg      <= lrev_next;
            rrev_reg      <= rrev_next;
            enable_reg    <= enable_next;
        end
    end

endmodule

FILE: design/dual_sign_magnitude_motor_pwm.sv
// Two-channel sign-magnitude motor PWM, phase-and-frequency-correct, top level.
// Latency: a request's result is valid in the cycle after its acceptance (one output register).
// Throughput: 1 transaction per cycle; the request side stalls only while a
// result is held unconsumed in the output register.
// Reset: counter 0 counting up, compares 0, both forward, outputs disabled,
// max_count 65535. Depends on dsmpwm_pkg, dsmpwm_if and dsmpwm_core.
module dual_sign_magnitude_motor_pwm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    dsmpwm_req_if.sink                           req,
    dsmpwm_rsp_if.source                         rsp,
    input  logic                                 cfg_we,
    input  logic [dsmpwm_pkg::DATA_W-1:0]        cfg_wdata
);
    logic                 accept;
    logic                 out_valid_reg;
    dsmpwm_pkg::result_t  result;
    dsmpwm_pkg::result_t  out_data_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    dsmpwm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_kind  (dsmpwm_pkg::req_kind_t'(req.req_type)),
        .duty      (req.duty),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.left_pin        = out_data_reg.left_pin;
    assign rsp.right_pin       = out_data_reg.right_pin;
    assign rsp.left_reverse    = out_data_reg.left_reverse;
    assign rsp.right_reverse   = out_data_reg.right_reverse;
    assign rsp.outputs_enabled = out_data_reg.outputs_enabled;
    assign rsp.left_readback   = out_data_reg.left_readback;
    assign rsp.right_readback  = out_data_reg.right_readback;
    assign rsp.count_now       = out_data_reg.count_now;

endmodule
